// File: hw/rtl/ack_wait_tracker_table_core_defines.svh
// Assertion macros for the acknowledgement-wait tracker.
// Depends on signals named clk and rst in the module that uses them.
`ifndef ACK_WAIT_TRACKER_TABLE_CORE_DEFINES_SVH
`define ACK_WAIT_TRACKER_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define AWT_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ack wait tracker: same-cycle check failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define AWT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ack wait tracker: next-cycle check failed");

`endif

// File: hw/rtl/awt_pkg.sv
// Shared types and codes of the acknowledgement-wait tracker.
// No dependencies; used by every module of the block.
`timescale 1ns / 1ps

package awt_pkg;

  localparam logic [1:0] CMD_ARM  = 2'd0;
  localparam logic [1:0] CMD_ACK  = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  localparam logic [2:0] OUT_ARMED   = 3'd0;
  localparam logic [2:0] OUT_FULL    = 3'd1;
  localparam logic [2:0] OUT_ACKED   = 3'd2;
  localparam logic [2:0] OUT_NACKED  = 3'd3;
  localparam logic [2:0] OUT_TIMEOUT = 3'd4;

  // Timeouts reported per tick are capped; the count needs four bits.
  localparam int RES_CNT_W = 4;
  localparam logic [RES_CNT_W-1:0] MAX_RESULTS = 4'd8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  seq_num;
    logic [31:0] wait_limit;
    logic        ack_positive;
  } awt_in_t;

  typedef struct packed {
    logic [2:0] outcome;
    logic [2:0] slot_index;
    logic [7:0] slot_seq;
    logic       last;
  } awt_out_t;

  // One slot's stored record in the slot memory.
  typedef struct packed {
    logic [7:0]  seq;
    logic [31:0] start;
    logic [31:0] limit;
  } awt_entry_t;

  typedef struct packed {
    logic arm_set;
    logic ack_clr;
    logic exp_clr;
  } awt_dir_ctl_t;

  typedef struct packed {
    logic free_found;
    logic match_found;
    logic exp_busy;
  } awt_dir_sts_t;

endpackage

// File: hw/rtl/awt_slot_mem.sv
// Slot record memory: one write port and one registered read port.
// Depends on awt_pkg for the record type.
`timescale 1ns / 1ps

module awt_slot_mem #(
  parameter int SLOTS = 8
) (
  input  logic                                            clk,
  input  logic                                            wr_en,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]   wr_addr,
  input  awt_pkg::awt_entry_t                             wr_data,
  input  logic                                            rd_en,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]   rd_addr,
  output awt_pkg::awt_entry_t                             rd_data
);

  awt_pkg::awt_entry_t mem [SLOTS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/awt_slot_dir.sv
// Slot directory: busy bits, sequence tags and the lowest-free and
// lowest-match priority encoders. Depends on awt_pkg.
`timescale 1ns / 1ps

module awt_slot_dir #(
  parameter int SLOTS = 8
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  awt_pkg::awt_dir_ctl_t                           ctl,
  input  logic [7:0]                                      key,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]   exp_idx,
  output awt_pkg::awt_dir_sts_t                           sts,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]   free_idx,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0]   match_idx
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  logic [SLOTS-1:0] busy_q;
  logic [7:0]       seq_q [SLOTS];
  logic             free_found;
  logic             match_found;

  // Scanning from the top down leaves the lowest hit in the index.
  always_comb begin
    free_found  = 1'b0;
    match_found = 1'b0;
    free_idx    = '0;
    match_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = IW'(i);
      end
      if (busy_q[i] && (seq_q[i] == key)) begin
        match_found = 1'b1;
        match_idx   = IW'(i);
      end
    end
  end

  assign sts.free_found  = free_found;
  assign sts.match_found = match_found;
  assign sts.exp_busy    = busy_q[exp_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy_q <= '0;
    end else begin
      if (ctl.arm_set && free_found) begin
        busy_q[free_idx] <= 1'b1;
      end
      if (ctl.ack_clr && match_found) begin
        busy_q[match_idx] <= 1'b0;
      end
      if (ctl.exp_clr) begin
        busy_q[exp_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.arm_set && free_found) begin
      seq_q[free_idx] <= key;
    end
  end

endmodule

// File: hw/rtl/ack_wait_tracker_table_core.sv
// Top level of the acknowledgement-wait tracker: command decode, tick scan
// sequencer and result register. Depends on awt_pkg, awt_slot_dir, awt_slot_mem
// and the assertion macros in ack_wait_tracker_table_core_defines.svh.
`timescale 1ns / 1ps
`include "ack_wait_tracker_table_core_defines.svh"

// A command beat is taken at a rising edge where start is high and busy is
// low. Arm, ack and the unused command code finish in the accepting cycle:
// busy stays low and the next beat can follow at once. A tick holds busy
// after it is accepted until its scan closes, because the expiry check walks
// the slot memory through its single read port, one slot per cycle, then
// makes the compare of the last record and then closes the scan. Each result
// appears on result for exactly one cycle with result_valid high; the
// receiver cannot stall it, so it must take every result as it comes. A tick
// reports at most eight timeouts, in rising slot order, and marks the final
// one with last; any further expired slots stay armed until a later tick.
// There is no clearing pass: reset clears the busy bits only, and slot
// records are acted on only while their slot is busy.
module ack_wait_tracker_table_core #(
  parameter int SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  awt_pkg::awt_in_t  item,
  output logic              busy,
  output logic              result_valid,
  output awt_pkg::awt_out_t result
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic state;
  logic [31:0] time_now;

  // Scan pipeline: issue_ptr is the next slot to read, cmp_idx the slot whose
  // record arrives from the memory in this cycle.
  logic [CW-1:0] issue_ptr;
  logic          cmp_vld;
  logic [IW-1:0] cmp_idx;

  // The newest timeout is held back one step so that last can be set on it
  // once the scan knows no further timeout follows.
  logic                          held;
  logic [IW-1:0]                 held_idx;
  logic [7:0]                    held_seq;
  logic [awt_pkg::RES_CNT_W-1:0] nres;

  awt_pkg::awt_dir_ctl_t dir_ctl;
  awt_pkg::awt_dir_sts_t dir_sts;
  logic [IW-1:0]         free_idx;
  logic [IW-1:0]         match_idx;

  awt_pkg::awt_entry_t wr_entry;
  awt_pkg::awt_entry_t rd_entry;
  logic                rd_en;

  logic        accept;
  logic        issue_done;
  logic        cap_hit;
  logic [31:0] elapsed;
  logic        expired;
  logic        scan_end;

  assign busy   = (state != ST_IDLE);
  assign accept = start && (state == ST_IDLE);

  assign issue_done = (issue_ptr == CW'(SLOTS));
  assign cap_hit    = (nres == awt_pkg::MAX_RESULTS);

  // Reads stop once the result cap is reached; a record already in flight
  // is then ignored by the expiry test below.
  assign rd_en = (state == ST_SCAN) && !issue_done && !cap_hit;

  // Elapsed time wraps modulo 2^32, as the counter does.
  assign elapsed  = time_now - rd_entry.start;
  assign expired  = cmp_vld && dir_sts.exp_busy && !cap_hit && (elapsed >= rd_entry.limit);
  assign scan_end = (state == ST_SCAN) && !cmp_vld && (issue_done || cap_hit);

  assign dir_ctl.arm_set = accept && (item.cmd == awt_pkg::CMD_ARM);
  assign dir_ctl.ack_clr = accept && (item.cmd == awt_pkg::CMD_ACK);
  assign dir_ctl.exp_clr = expired;

  assign wr_entry.seq   = item.seq_num;
  assign wr_entry.start = time_now;
  assign wr_entry.limit = item.wait_limit;

  awt_slot_dir #(
    .SLOTS (SLOTS)
  ) u_dir (
    .clk       (clk),
    .rst       (rst),
    .ctl       (dir_ctl),
    .key       (item.seq_num),
    .exp_idx   (cmp_idx),
    .sts       (dir_sts),
    .free_idx  (free_idx),
    .match_idx (match_idx)
  );

  // Writes happen only on an arm beat while idle and reads only while
  // scanning, so the two ports never touch the same record in one cycle.
  awt_slot_mem #(
    .SLOTS (SLOTS)
  ) u_mem (
    .clk     (clk),
    .wr_en   (dir_ctl.arm_set && dir_sts.free_found),
    .wr_addr (free_idx),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (issue_ptr[IW-1:0]),
    .rd_data (rd_entry)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      time_now     <= '0;
      issue_ptr    <= '0;
      cmp_vld      <= 1'b0;
      held         <= 1'b0;
      nres         <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            unique case (item.cmd)
              awt_pkg::CMD_ARM: begin
                result_valid    <= 1'b1;
                result.slot_seq <= item.seq_num;
                result.last     <= 1'b1;
                if (dir_sts.free_found) begin
                  result.outcome    <= awt_pkg::OUT_ARMED;
                  result.slot_index <= 3'(free_idx);
                end else begin
                  result.outcome    <= awt_pkg::OUT_FULL;
                  result.slot_index <= '0;
                end
              end
              awt_pkg::CMD_ACK: begin
                // A match means the stored tag equals the requested sequence.
                if (dir_sts.match_found) begin
                  result_valid      <= 1'b1;
                  result.outcome    <= item.ack_positive ? awt_pkg::OUT_ACKED
                                                         : awt_pkg::OUT_NACKED;
                  result.slot_index <= 3'(match_idx);
                  result.slot_seq   <= item.seq_num;
                  result.last       <= 1'b1;
                end
              end
              awt_pkg::CMD_TICK: begin
                time_now  <= time_now + 32'd1;
                state     <= ST_SCAN;
                issue_ptr <= '0;
                cmp_vld   <= 1'b0;
                held      <= 1'b0;
                nres      <= '0;
              end
              default: begin
              end
            endcase
          end
        end
        ST_SCAN: begin
          cmp_vld <= rd_en;
          cmp_idx <= issue_ptr[IW-1:0];
          if (rd_en) begin
            issue_ptr <= issue_ptr + CW'(1);
          end
          if (expired) begin
            nres     <= nres + awt_pkg::RES_CNT_W'(1);
            held     <= 1'b1;
            held_idx <= cmp_idx;
            held_seq <= rd_entry.seq;
            // A new timeout proves the held one is not the final result.
            if (held) begin
              result_valid      <= 1'b1;
              result.outcome    <= awt_pkg::OUT_TIMEOUT;
              result.slot_index <= 3'(held_idx);
              result.slot_seq   <= held_seq;
              result.last       <= 1'b0;
            end
          end
          if (scan_end) begin
            state <= ST_IDLE;
            held  <= 1'b0;
            if (held) begin
              result_valid      <= 1'b1;
              result.outcome    <= awt_pkg::OUT_TIMEOUT;
              result.slot_index <= 3'(held_idx);
              result.slot_seq   <= held_seq;
              result.last       <= 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Only a tick may occupy the block beyond its accepting cycle.
  `AWT_ASSERT_NEXT(a_short_cmd_no_busy, accept && (item.cmd != awt_pkg::CMD_TICK), !busy)

  // Only timeouts come in chains; every other result is final.
  `AWT_ASSERT_IMPLIES(a_chain_is_timeout, result_valid && !result.last,
                      result.outcome == awt_pkg::OUT_TIMEOUT)

  // A scan that held a timeout closes by delivering it as the final result.
  `AWT_ASSERT_IMPLIES(a_scan_close_last, $fell(busy) && $past(held),
                      result_valid && result.last && (result.outcome == awt_pkg::OUT_TIMEOUT))

  // The per-tick timeout count never passes the cap.
  `AWT_ASSERT_IMPLIES(a_result_cap, state == ST_SCAN, nres <= awt_pkg::MAX_RESULTS)

endmodule

// File: test/tb.sv
// Self-checking testbench for ack_wait_tracker_table_core: a directed table
// of command beats, then constrained-random traffic checked against a local
// model of the wait table. Depends on awt_pkg and the block's RTL only.
`timescale 1ns / 1ps

module tb;

  localparam int SLOTS = 8;
  localparam int RANDOM_BEATS = 350;
  localparam int QUIET_TAIL = 50;       // last random beats sent back to back
  localparam int STALL_LIMIT = 2000;    // cycles with no beat and no result
  localparam int DRAIN_CYCLES = SLOTS + 8;

  // The one command code the block ignores.
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // How a row of the directed table is checked.
  typedef enum logic [1:0] {
    BY_MODEL,    // expected results come from the local model
    TYPED_ONE,   // exactly the one result typed in the row
    TYPED_NONE   // no result at all
  } row_check_t;

  typedef struct {
    awt_pkg::awt_in_t  beat;
    row_check_t        check;
    awt_pkg::awt_out_t typed;
  } plan_row_t;

  logic              clk;
  logic              rst;
  logic              start;
  awt_pkg::awt_in_t  item;
  logic              busy;
  logic              result_valid;
  awt_pkg::awt_out_t result;

  ack_wait_tracker_table_core #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .item        (item),
    .busy        (busy),
    .result_valid(result_valid),
    .result      (result)
  );

  // Model of the wait table: busy bits, stored records and the tick counter.
  logic        tbl_busy [SLOTS];
  logic [7:0]  tbl_seq  [SLOTS];
  logic [31:0] tbl_start[SLOTS];
  logic [31:0] tbl_limit[SLOTS];
  logic [31:0] tick_count;

  awt_pkg::awt_out_t fresh_q[$];     // results caused by the beat just accepted
  awt_pkg::awt_out_t pending_q[$];   // results still owed by the block, oldest first
  plan_row_t         plan_q[$];

  int mismatch_count;
  int stall_cycles;
  int seen_by_outcome[5];
  int max_burst;

  awt_pkg::awt_out_t want;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int want_v, input int got_v);
    $display("[%0t] %s: expected %0d, got %0d", $time, what, want_v, got_v);
    mismatch_count++;
  endtask

  function automatic awt_pkg::awt_in_t mk_beat(input logic [1:0] cmd, input logic [7:0] seq,
                                               input logic [31:0] lim, input logic pos);
    awt_pkg::awt_in_t b;
    b.cmd          = cmd;
    b.seq_num      = seq;
    b.wait_limit   = lim;
    b.ack_positive = pos;
    return b;
  endfunction

  function automatic awt_pkg::awt_out_t mk_result(input logic [2:0] outcome,
                                                  input logic [2:0] idx,
                                                  input logic [7:0] seq, input logic last);
    awt_pkg::awt_out_t r;
    r.outcome    = outcome;
    r.slot_index = idx;
    r.slot_seq   = seq;
    r.last       = last;
    return r;
  endfunction

  task automatic add_row(input awt_pkg::awt_in_t beat, input row_check_t check,
                         input awt_pkg::awt_out_t typed);
    plan_row_t row;
    row.beat  = beat;
    row.check = check;
    row.typed = typed;
    plan_q.push_back(row);
  endtask

  // Applies one accepted beat to the model and leaves its results in fresh_q.
  task automatic update_wait_table(input awt_pkg::awt_in_t beat);
    int n;
    bit done;
    n = 0;
    done = 1'b0;
    fresh_q.delete();
    case (beat.cmd)
      awt_pkg::CMD_ARM: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && !tbl_busy[i]) begin
            tbl_busy[i]  = 1'b1;
            tbl_seq[i]   = beat.seq_num;
            tbl_start[i] = tick_count;
            tbl_limit[i] = beat.wait_limit;
            fresh_q.push_back(mk_result(awt_pkg::OUT_ARMED, i[2:0], beat.seq_num, 1'b1));
            done = 1'b1;
          end
        end
        if (!done) begin
          fresh_q.push_back(mk_result(awt_pkg::OUT_FULL, 3'd0, beat.seq_num, 1'b1));
        end
      end
      awt_pkg::CMD_ACK: begin
        // The lowest waiting slot with a matching sequence is closed.
        for (int i = 0; i < SLOTS; i++) begin
          if (!done && tbl_busy[i] && tbl_seq[i] == beat.seq_num) begin
            tbl_busy[i] = 1'b0;
            fresh_q.push_back(mk_result(beat.ack_positive ? awt_pkg::OUT_ACKED
                                                          : awt_pkg::OUT_NACKED,
                                        i[2:0], tbl_seq[i], 1'b1));
            done = 1'b1;
          end
        end
      end
      awt_pkg::CMD_TICK: begin
        tick_count = tick_count + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          // Elapsed time wraps with the 32-bit counter.
          if (n < int'(awt_pkg::MAX_RESULTS) && tbl_busy[i] &&
              (tick_count - tbl_start[i]) >= tbl_limit[i]) begin
            tbl_busy[i] = 1'b0;
            fresh_q.push_back(mk_result(awt_pkg::OUT_TIMEOUT, i[2:0], tbl_seq[i], 1'b0));
            n++;
          end
        end
        if (n > 0) begin
          fresh_q[n-1].last = 1'b1;
        end
      end
      default: begin
        // The unused command code leaves everything untouched.
      end
    endcase
  endtask

  // Holds start high until the block takes the beat, then predicts it.
  // start is left high so a following beat can go out without a gap.
  task automatic send_beat(input awt_pkg::awt_in_t beat);
    item  <= beat;
    start <= 1'b1;
    do begin
      @(posedge clk);
    end while (busy);
    update_wait_table(beat);
  endtask

  task automatic pause_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Random beat, mostly well formed: acks usually name a sequence that is
  // waiting, and most timeouts are short enough to expire within the run.
  function automatic awt_pkg::awt_in_t pick_beat();
    int          roll;
    int          pick;
    logic [7:0]  seq;
    logic [31:0] lim;
    roll = $urandom_range(0, 99);
    if ($urandom_range(0, 1) == 0) begin
      seq = 8'($urandom_range(0, 15));
    end else begin
      seq = 8'($urandom_range(0, 255));
    end
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      lim = 32'($urandom_range(0, 12));
    end else if (pick < 9) begin
      lim = 32'($urandom_range(0, 200));
    end else begin
      lim = $urandom;
    end
    if (roll < 40) begin
      return mk_beat(awt_pkg::CMD_ARM, seq, lim, 1'($urandom_range(0, 1)));
    end else if (roll < 70) begin
      pick = $urandom_range(0, SLOTS - 1);
      if ($urandom_range(0, 9) < 7 && tbl_busy[pick]) begin
        seq = tbl_seq[pick];
      end
      return mk_beat(awt_pkg::CMD_ACK, seq, $urandom, 1'($urandom_range(0, 1)));
    end else if (roll < 95) begin
      return mk_beat(awt_pkg::CMD_TICK, seq, $urandom, 1'($urandom_range(0, 1)));
    end
    return mk_beat(CMD_UNUSED, seq, $urandom, 1'($urandom_range(0, 1)));
  endfunction

  // Result checker: the block cannot be stalled, so every strobe is taken.
  always @(posedge clk) begin
    if (!rst && result_valid) begin
      if (result.outcome <= awt_pkg::OUT_TIMEOUT) begin
        seen_by_outcome[result.outcome]++;
      end
      if (pending_q.size() == 0) begin
        report_mismatch("result with nothing pending, outcome", -1, int'(result.outcome));
      end else begin
        want = pending_q.pop_front();
        if (result.outcome !== want.outcome) begin
          report_mismatch("outcome", int'(want.outcome), int'(result.outcome));
        end
        if (result.slot_index !== want.slot_index) begin
          report_mismatch("slot_index", int'(want.slot_index), int'(result.slot_index));
        end
        if (result.slot_seq !== want.slot_seq) begin
          report_mismatch("slot_seq", int'(want.slot_seq), int'(result.slot_seq));
        end
        if (result.last !== want.last) begin
          report_mismatch("last", int'(want.last), int'(result.last));
        end
      end
    end
  end

  // Watchdog: a run that stops moving is a failure.
  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("ack_wait_tracker_table_core: mismatch");
        $finish;
      end
    end
  end

  initial begin
    int               sent;
    int               beats_done;
    bit               mid_drained;
    awt_pkg::awt_in_t beat;

    rst   <= 1'b1;
    start <= 1'b0;
    item  <= '0;
    mismatch_count = 0;
    max_burst      = 0;
    mid_drained    = 1'b0;
    tick_count     = '0;
    for (int i = 0; i < SLOTS; i++) begin
      tbl_busy[i]  = 1'b0;
      tbl_seq[i]   = '0;
      tbl_start[i] = '0;
      tbl_limit[i] = '0;
    end
    for (int k = 0; k < 5; k++) begin
      seen_by_outcome[k] = 0;
    end

    // Directed table. Time starts at zero; a zero timeout closes on the next
    // tick, and the table is filled to show the full status.
    add_row(mk_beat(awt_pkg::CMD_ARM, 8'h00, 32'd0, 1'b0), TYPED_ONE,
            mk_result(awt_pkg::OUT_ARMED, 3'd0, 8'h00, 1'b1));
    add_row(mk_beat(awt_pkg::CMD_TICK, 8'h00, 32'd0, 1'b0), TYPED_ONE,
            mk_result(awt_pkg::OUT_TIMEOUT, 3'd0, 8'h00, 1'b1));
    // A tick with nothing waiting only moves time.
    add_row(mk_beat(awt_pkg::CMD_TICK, 8'hFF, 32'hFFFF_FFFF, 1'b1), TYPED_NONE, '0);
    add_row(mk_beat(awt_pkg::CMD_ARM, 8'hFF, 32'hFFFF_FFFF, 1'b1), TYPED_ONE,
            mk_result(awt_pkg::OUT_ARMED, 3'd0, 8'hFF, 1'b1));
    add_row(mk_beat(awt_pkg::CMD_ARM, 8'hA5, 32'd3, 1'b0), TYPED_ONE,
            mk_result(awt_pkg::OUT_ARMED, 3'd1, 8'hA5, 1'b1));
    add_row(mk_beat(awt_pkg::CMD_ARM, 8'h5A, 32'd1, 1'b0), TYPED_ONE,
            mk_result(awt_pkg::OUT_ARMED, 3'd2, 8'h5A, 1'b1));
    for (int s = 3; s < SLOTS; s++) begin
      add_row(mk_beat(awt_pkg::CMD_ARM, 8'h0D + 8'(s), 32'd4, 1'b0), TYPED_ONE,
              mk_result(awt_pkg::OUT_ARMED, 3'(s), 8'h0D + 8'(s), 1'b1));
    end
    add_row(mk_beat(awt_pkg::CMD_ARM, 8'h77, 32'd9, 1'b1), TYPED_ONE,
            mk_result(awt_pkg::OUT_FULL, 3'd0, 8'h77, 1'b1));
    // An ack that names no waiting sequence is dropped silently.
    add_row(mk_beat(awt_pkg::CMD_ACK, 8'h33, 32'd0, 1'b1), TYPED_NONE, '0);
    add_row(mk_beat(awt_pkg::CMD_ACK, 8'hA5, 32'd0, 1'b1), TYPED_ONE,
            mk_result(awt_pkg::OUT_ACKED, 3'd1, 8'hA5, 1'b1));
    // Slot 1 now repeats the sequence of slot 3; the lower slot must win.
    add_row(mk_beat(awt_pkg::CMD_ARM, 8'h10, 32'd2, 1'b0), TYPED_ONE,
            mk_result(awt_pkg::OUT_ARMED, 3'd1, 8'h10, 1'b1));
    add_row(mk_beat(awt_pkg::CMD_ACK, 8'h10, 32'd0, 1'b0), TYPED_ONE,
            mk_result(awt_pkg::OUT_NACKED, 3'd1, 8'h10, 1'b1));
    add_row(mk_beat(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 1'b1), TYPED_NONE, '0);
    // These ticks expire slot 2 first, then slots 3 to 7 all on one tick.
    for (int t = 0; t < 5; t++) begin
      add_row(mk_beat(awt_pkg::CMD_TICK, 8'h00, 32'd0, 1'b0), BY_MODEL, '0);
    end
    add_row(mk_beat(awt_pkg::CMD_ACK, 8'hFF, 32'h0000_0000, 1'b1), TYPED_ONE,
            mk_result(awt_pkg::OUT_ACKED, 3'd0, 8'hFF, 1'b1));

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    foreach (plan_q[r]) begin
      if ($urandom_range(0, 2) == 0) begin
        pause_sender($urandom_range(1, 8));
      end
      send_beat(plan_q[r].beat);
      case (plan_q[r].check)
        TYPED_ONE: begin
          if (fresh_q.size() != 1 || fresh_q[0] != plan_q[r].typed) begin
            report_mismatch("model disagrees with directed row", r, fresh_q.size());
          end
          pending_q.push_back(plan_q[r].typed);
        end
        TYPED_NONE: begin
          if (fresh_q.size() != 0) begin
            report_mismatch("model disagrees with directed row", r, fresh_q.size());
          end
        end
        default: begin
          foreach (fresh_q[k]) pending_q.push_back(fresh_q[k]);
        end
      endcase
    end

    // Random traffic. Ignored command codes do not count toward the total.
    beats_done = 0;
    while (beats_done < RANDOM_BEATS) begin
      // Halfway through, hold the sender until every owed result is out.
      if (!mid_drained && beats_done >= RANDOM_BEATS / 2) begin
        mid_drained = 1'b1;
        start <= 1'b0;
        do begin
          @(posedge clk);
        end while (pending_q.size() != 0);
      end else if (beats_done < RANDOM_BEATS - QUIET_TAIL &&
                   $urandom_range(0, 3) == 0) begin
        pause_sender($urandom_range(1, 8));
      end
      // Now and then a run of arms, to reach the full table.
      if ($urandom_range(0, 19) == 0) begin
        sent = $urandom_range(6, 12);
      end else begin
        sent = 1;
      end
      for (int j = 0; j < sent; j++) begin
        beat = pick_beat();
        if (sent > 1) begin
          beat.cmd = awt_pkg::CMD_ARM;
        end
        send_beat(beat);
        foreach (fresh_q[k]) pending_q.push_back(fresh_q[k]);
        if (fresh_q.size() > max_burst) begin
          max_burst = fresh_q.size();
        end
        if (beat.cmd != CMD_UNUSED) begin
          beats_done++;
        end
      end
    end

    start <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_q.size() != 0) begin
      report_mismatch("results never delivered", 0, pending_q.size());
    end

    $display("Covered %0d directed and %0d random beats; largest expiry burst %0d.",
             plan_q.size(), beats_done, max_burst);
    $display("Seen: %0d armed, %0d full, %0d acked, %0d nacked, %0d timed out.",
             seen_by_outcome[awt_pkg::OUT_ARMED], seen_by_outcome[awt_pkg::OUT_FULL],
             seen_by_outcome[awt_pkg::OUT_ACKED], seen_by_outcome[awt_pkg::OUT_NACKED],
             seen_by_outcome[awt_pkg::OUT_TIMEOUT]);
    if (mismatch_count == 0) begin
      $display("ack_wait_tracker_table_core: match");
    end else begin
      $display("ack_wait_tracker_table_core: mismatch");
    end
    $finish;
  end

endmodule
